### sv/light_tracker_stepper_drive_assert.svh
// Assertion macros shared by the light tracker checkers
`ifndef LIGHT_TRACKER_STEPPER_DRIVE_ASSERT_SVH
`define LIGHT_TRACKER_STEPPER_DRIVE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset
`define LTSD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("light tracker check failed");

// Next-cycle implication, clocked on clk, off during reset
`define LTSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("light tracker check failed");

`endif

### sv/ltsd_pkg.sv
// Shared widths, codes and types of the light tracker stepper drive
`default_nettype none

package ltsd_pkg;

	// Field widths
	localparam int SAMPLE_BITS    = 12;
	localparam int THRESH_BITS    = 12;
	localparam int DELAY_BITS     = 16;
	localparam int SEQ_BITS       = 8;
	localparam int COIL_BITS      = 4;
	localparam int STEP_BITS      = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CMP_BITS       = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_DELAY = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SEQUENCES = 2'd2;

	// Register reset values
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd100;
	localparam logic [DELAY_BITS-1:0]  DELAY_RESET  = 16'd2253;
	localparam logic [SEQ_BITS-1:0]    SEQ_RESET    = 8'd25;

	// Request kinds
	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_SAMPLES = 1'b1;

	// Directions
	localparam logic DIR_CW  = 1'b0;
	localparam logic DIR_ACW = 1'b1;

	typedef struct packed {
		logic [THRESH_BITS-1:0] light_threshold;
		logic [DELAY_BITS-1:0]  step_delay;
		logic [SEQ_BITS-1:0]    sequences_per_move;
	} cfg_t;

	// Per-axis move decision from one sample set
	typedef struct packed {
		logic move_first;
		logic dir_first;
		logic move_second;
		logic dir_second;
	} judge_t;

	typedef struct packed {
		logic [COIL_BITS-1:0] coil_first;
		logic [COIL_BITS-1:0] coil_second;
		logic                 busy;
		logic                 taken;
	} result_t;

	// Wave drive: one coil on per step
	function automatic logic [COIL_BITS-1:0] coil_pattern(input logic [STEP_BITS-1:0] idx);
		return COIL_BITS'(1) << idx;
	endfunction

endpackage

`default_nettype wire

### sv/ltsd_judge.sv
// Compares the reference sample with both axis samples against the threshold
`default_nettype none

module ltsd_judge (
	input  wire logic [ltsd_pkg::SAMPLE_BITS-1:0] light_ref,
	input  wire logic [ltsd_pkg::SAMPLE_BITS-1:0] light_first,
	input  wire logic [ltsd_pkg::SAMPLE_BITS-1:0] light_second,
	input  wire logic [ltsd_pkg::THRESH_BITS-1:0] threshold,
	output ltsd_pkg::judge_t                      judge
);

	// {move, direction} for one sensor pair
	function automatic logic [1:0] judge_pair(
		input logic [ltsd_pkg::SAMPLE_BITS-1:0] ref_v,
		input logic [ltsd_pkg::SAMPLE_BITS-1:0] oth_v,
		input logic [ltsd_pkg::THRESH_BITS-1:0] thr_v
	);
		logic [ltsd_pkg::CMP_BITS-1:0] diff_down;
		logic [ltsd_pkg::CMP_BITS-1:0] diff_up;
		logic [ltsd_pkg::CMP_BITS-1:0] thr_x;
		diff_down = ltsd_pkg::CMP_BITS'(ref_v) - ltsd_pkg::CMP_BITS'(oth_v);
		diff_up   = ltsd_pkg::CMP_BITS'(oth_v) - ltsd_pkg::CMP_BITS'(ref_v);
		thr_x     = ltsd_pkg::CMP_BITS'(thr_v);
		if (ref_v > oth_v && diff_down > thr_x) begin
			return {1'b1, ltsd_pkg::DIR_CW};
		end else if (oth_v > ref_v && diff_up > thr_x) begin
			return {1'b1, ltsd_pkg::DIR_ACW};
		end
		return 2'b00;
	endfunction

	assign {judge.move_first, judge.dir_first}   = judge_pair(light_ref, light_first, threshold);
	assign {judge.move_second, judge.dir_second} = judge_pair(light_ref, light_second, threshold);

endmodule

`default_nettype wire

### sv/ltsd_motion.sv
// Move sequencer: phase, step and delay counters, coil patterns
`default_nettype none

module ltsd_motion (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic             kind,
	input  wire ltsd_pkg::judge_t judge,
	input  wire ltsd_pkg::cfg_t   cfg,
	output ltsd_pkg::result_t     res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FIRST,
		PH_SECOND
	} phase_t;

	localparam logic [ltsd_pkg::STEP_BITS-1:0] IDX_LOW  = '0;
	localparam logic [ltsd_pkg::STEP_BITS-1:0] IDX_HIGH = '1;

	phase_t                              phase_q, phase_d;
	logic                                pending_q, pending_d;
	logic                                second_dir_q, second_dir_d;
	logic                                dir_q, dir_d;
	logic [ltsd_pkg::STEP_BITS-1:0]      idx_q, idx_d;
	logic [ltsd_pkg::SEQ_BITS-1:0]       seq_q, seq_d;
	logic [ltsd_pkg::DELAY_BITS-1:0]     delay_q, delay_d;
	logic [ltsd_pkg::COIL_BITS-1:0]      pat_first_q, pat_first_d;
	logic [ltsd_pkg::COIL_BITS-1:0]      pat_second_q, pat_second_d;
	logic                                taken_d;
	logic [ltsd_pkg::DELAY_BITS-1:0]     reload;
	logic [ltsd_pkg::SEQ_BITS-1:0]       seq_dec;
	logic                                run_done;
	logic                                spm_nz;

	// Next state for one request
	always_comb begin
		phase_d      = phase_q;
		pending_d    = pending_q;
		second_dir_d = second_dir_q;
		dir_d        = dir_q;
		idx_d        = idx_q;
		seq_d        = seq_q;
		delay_d      = delay_q;
		pat_first_d  = pat_first_q;
		pat_second_d = pat_second_q;
		taken_d      = 1'b0;
		// zero delay holds for one tick
		reload   = (cfg.step_delay == '0) ? ltsd_pkg::DELAY_BITS'(1) : cfg.step_delay;
		seq_dec  = seq_q - ltsd_pkg::SEQ_BITS'(1);
		run_done = dir_q ? (idx_q == IDX_HIGH) : (idx_q == IDX_LOW);
		spm_nz   = cfg.sequences_per_move != '0;

		if (kind == ltsd_pkg::KIND_TICK) begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_FIRST, PH_SECOND: begin
					if (delay_q > ltsd_pkg::DELAY_BITS'(1)) begin
						delay_d = delay_q - ltsd_pkg::DELAY_BITS'(1);
					end else if (run_done && seq_dec == '0) begin
						// move done: chain into the pending second axis if any
						seq_d     = seq_dec;
						delay_d   = '0;
						pending_d = 1'b0;
						if (phase_q == PH_FIRST && pending_q && spm_nz) begin
							phase_d      = PH_SECOND;
							dir_d        = second_dir_q;
							idx_d        = second_dir_q ? IDX_LOW : IDX_HIGH;
							seq_d        = cfg.sequences_per_move;
							delay_d      = reload;
							pat_second_d = ltsd_pkg::coil_pattern(idx_d);
						end else begin
							phase_d = PH_IDLE;
						end
					end else begin
						// advance one step
						if (run_done) begin
							seq_d = seq_dec;
						end
						idx_d   = dir_q ? (idx_q + ltsd_pkg::STEP_BITS'(1))
						                : (idx_q - ltsd_pkg::STEP_BITS'(1));
						delay_d = reload;
						if (phase_q == PH_FIRST) begin
							pat_first_d = ltsd_pkg::coil_pattern(idx_d);
						end else begin
							pat_second_d = ltsd_pkg::coil_pattern(idx_d);
						end
					end
				end
				default: begin
				end
			endcase
		end else if (phase_q == PH_IDLE) begin
			// sample set taken only while idle
			taken_d   = 1'b1;
			pending_d = 1'b0;
			if (judge.move_first && spm_nz) begin
				phase_d      = PH_FIRST;
				dir_d        = judge.dir_first;
				idx_d        = judge.dir_first ? IDX_LOW : IDX_HIGH;
				seq_d        = cfg.sequences_per_move;
				delay_d      = reload;
				pat_first_d  = ltsd_pkg::coil_pattern(idx_d);
				pending_d    = judge.move_second;
				second_dir_d = judge.dir_second;
			end else if (judge.move_second && spm_nz) begin
				phase_d      = PH_SECOND;
				dir_d        = judge.dir_second;
				idx_d        = judge.dir_second ? IDX_LOW : IDX_HIGH;
				seq_d        = cfg.sequences_per_move;
				delay_d      = reload;
				pat_second_d = ltsd_pkg::coil_pattern(idx_d);
			end
		end
	end

	// Result for this request, registered by the caller
	assign res.coil_first  = pat_first_d;
	assign res.coil_second = pat_second_d;
	assign res.busy        = (phase_d != PH_IDLE);
	assign res.taken       = taken_d;

	// State
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			pending_q    <= 1'b0;
			second_dir_q <= 1'b0;
			dir_q        <= 1'b0;
			idx_q        <= '0;
			seq_q        <= '0;
			delay_q      <= '0;
			pat_first_q  <= '0;
			pat_second_q <= '0;
		end else if (fire) begin
			phase_q      <= phase_d;
			pending_q    <= pending_d;
			second_dir_q <= second_dir_d;
			dir_q        <= dir_d;
			idx_q        <= idx_d;
			seq_q        <= seq_d;
			delay_q      <= delay_d;
			pat_first_q  <= pat_first_d;
			pat_second_q <= pat_second_d;
		end
	end

endmodule

`default_nettype wire

### sv/light_tracker_stepper_drive.sv
// Pipeline: two register stages (input, result); a request passes the input register, then the result register.
// Throughput: one request per cycle while results are taken; the sequencer state updates once per request.
// While a result waits to be taken, the input register holds its request and accepts a new one only when empty.
// Reset (arst_n low): motors idle, sequencer coil patterns off, configuration registers at their defaults.
// Top level of the two-axis light tracker wave-drive stepper controller
`default_nettype none

module light_tracker_stepper_drive (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_we,
	input  wire logic [ltsd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [ltsd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// request channel
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 kind,
	input  wire logic [ltsd_pkg::SAMPLE_BITS-1:0]     light_ref,
	input  wire logic [ltsd_pkg::SAMPLE_BITS-1:0]     light_first,
	input  wire logic [ltsd_pkg::SAMPLE_BITS-1:0]     light_second,
	// result channel
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [ltsd_pkg::COIL_BITS-1:0]            coil_first,
	output logic [ltsd_pkg::COIL_BITS-1:0]            coil_second,
	output logic                                      busy_res,
	output logic                                      sample_taken
);

	ltsd_pkg::cfg_t    cfg_q;
	ltsd_pkg::judge_t  judge_c;
	ltsd_pkg::judge_t  judge_s1;
	logic              kind_s1;
	logic              valid_s1;
	ltsd_pkg::result_t res_c;
	ltsd_pkg::result_t result_q;
	logic              out_valid_q;
	logic              advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.light_threshold    <= ltsd_pkg::THRESH_RESET;
			cfg_q.step_delay         <= ltsd_pkg::DELAY_RESET;
			cfg_q.sequences_per_move <= ltsd_pkg::SEQ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ltsd_pkg::CFG_THRESHOLD:
					cfg_q.light_threshold <= cfg_data[ltsd_pkg::THRESH_BITS-1:0];
				ltsd_pkg::CFG_STEP_DELAY:
					cfg_q.step_delay <= cfg_data[ltsd_pkg::DELAY_BITS-1:0];
				ltsd_pkg::CFG_SEQUENCES:
					cfg_q.sequences_per_move <= cfg_data[ltsd_pkg::SEQ_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Flow control
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Sample comparison ahead of the input register
	ltsd_judge u_judge (
		.light_ref    (light_ref),
		.light_first  (light_first),
		.light_second (light_second),
		.threshold    (cfg_q.light_threshold),
		.judge        (judge_c)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			judge_s1 <= judge_c;
		end
	end

	// Sequencer, updated when the stage-one request moves on
	ltsd_motion u_motion (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.kind   (kind_s1),
		.judge  (judge_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_q <= res_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign coil_first   = result_q.coil_first;
	assign coil_second  = result_q.coil_second;
	assign busy_res     = result_q.busy;
	assign sample_taken = result_q.taken;

endmodule

`default_nettype wire

### sv/ltsd_checker.sv
// Port-level checks on the light tracker stepper drive, bound to the top level
`default_nettype none

`include "light_tracker_stepper_drive_assert.svh"

module ltsd_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [ltsd_pkg::COIL_BITS-1:0]       coil_first,
	input wire logic [ltsd_pkg::COIL_BITS-1:0]       coil_second,
	input wire logic                                 busy_res,
	input wire logic                                 sample_taken
);

	// stalled result holds
	`LTSD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({coil_first, coil_second, busy_res, sample_taken}))

	// wave drive: never more than one coil per motor
	`LTSD_ASSERT_IMPL(a_coil_onehot, out_valid, $onehot0(coil_first) && $onehot0(coil_second))

	// empty result register never blocks requests
	`LTSD_ASSERT_IMPL(a_ready_when_drained, !out_valid, in_ready)

endmodule

bind light_tracker_stepper_drive ltsd_checker u_ltsd_checker (.*);

`default_nettype wire

### tb/tb.sv
// Self-checking bench for the light tracker stepper drive with a built-in predictor
module tb;
	import ltsd_pkg::*;

	localparam int RUN_LIMIT       = 200000;
	localparam int HOLD_CYCLES     = 300;
	localparam int DRAIN_CYCLES    = 6;
	localparam int MAX_REPORTS     = 10;
	localparam int RANDOM_PHASES   = 4;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
	localparam logic [STEP_BITS-1:0] STEP_FIRST = 2'd0;
	localparam logic [STEP_BITS-1:0] STEP_LAST  = 2'd3;

	typedef enum logic [1:0] {AXIS_IDLE, AXIS_FIRST, AXIS_SECOND} axis_phase_e;
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC} rx_mode_e;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      kind = KIND_TICK;
	logic [SAMPLE_BITS-1:0]    light_ref = '0;
	logic [SAMPLE_BITS-1:0]    light_first = '0;
	logic [SAMPLE_BITS-1:0]    light_second = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [COIL_BITS-1:0]      coil_first;
	logic [COIL_BITS-1:0]      coil_second;
	logic                      busy_res;
	logic                      sample_taken;

	light_tracker_stepper_drive u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.light_ref    (light_ref),
		.light_first  (light_first),
		.light_second (light_second),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.coil_first   (coil_first),
		.coil_second  (coil_second),
		.busy_res     (busy_res),
		.sample_taken (sample_taken)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Expected drive results, oldest first
	result_t drive_expect_q[$];
	result_t got_res;
	result_t want_res;

	int cycle_count     = 0;
	int err_count       = 0;
	int reqs_sent       = 0;
	int results_checked = 0;
	int moves_started   = 0;
	int samples_dropped = 0;
	int burst_left      = 0;
	bit steady_send     = 1'b0;
	bit hold_off_req    = 1'b0;

	// Predictor state
	cfg_t                   cfg_model;
	axis_phase_e            phase_m;
	logic                   second_pend_m;
	logic                   second_dir_m;
	logic                   dir_m;
	logic [STEP_BITS-1:0]   step_m;
	logic [SEQ_BITS-1:0]    seq_left_m;
	logic [DELAY_BITS-1:0]  delay_left_m;
	logic [COIL_BITS-1:0]   first_coils_m;
	logic [COIL_BITS-1:0]   second_coils_m;

	function automatic void reset_model();
		cfg_model.light_threshold    = THRESH_RESET;
		cfg_model.step_delay         = DELAY_RESET;
		cfg_model.sequences_per_move = SEQ_RESET;
		phase_m        = AXIS_IDLE;
		second_pend_m  = 1'b0;
		second_dir_m   = DIR_CW;
		dir_m          = DIR_CW;
		step_m         = STEP_FIRST;
		seq_left_m     = '0;
		delay_left_m   = '0;
		first_coils_m  = '0;
		second_coils_m = '0;
	endfunction

	// A zero delay still holds a pattern for one tick
	function automatic logic [DELAY_BITS-1:0] hold_ticks();
		return (cfg_model.step_delay == '0) ? DELAY_BITS'(1) : cfg_model.step_delay;
	endfunction

	// One-hot wave drive on the motor that is moving
	function automatic void drive_coils();
		logic [COIL_BITS-1:0] pat;
		pat = '0;
		pat[step_m] = 1'b1;
		if (phase_m == AXIS_FIRST)
			first_coils_m = pat;
		else if (phase_m == AXIS_SECOND)
			second_coils_m = pat;
	endfunction

	function automatic bit begin_move(input axis_phase_e axis, input logic dir);
		if (cfg_model.sequences_per_move == '0)
			return 1'b0;
		phase_m      = axis;
		dir_m        = dir;
		step_m       = (dir == DIR_ACW) ? STEP_FIRST : STEP_LAST;
		seq_left_m   = cfg_model.sequences_per_move;
		delay_left_m = hold_ticks();
		drive_coils();
		moves_started++;
		return 1'b1;
	endfunction

	// Pair decision: move toward the brighter sensor when the gap beats the threshold
	function automatic bit needs_move(input logic [SAMPLE_BITS-1:0] base,
			input logic [SAMPLE_BITS-1:0] other, output logic dir);
		dir = DIR_CW;
		if (base > other && base - other > cfg_model.light_threshold)
			return 1'b1;
		if (other > base && other - base > cfg_model.light_threshold) begin
			dir = DIR_ACW;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void finish_move();
		if (phase_m == AXIS_FIRST && second_pend_m) begin
			second_pend_m = 1'b0;
			if (begin_move(AXIS_SECOND, second_dir_m))
				return;
		end
		second_pend_m = 1'b0;
		phase_m = AXIS_IDLE;
	endfunction

	function automatic void count_tick();
		logic run_done;
		if (phase_m == AXIS_IDLE)
			return;
		if (delay_left_m > DELAY_BITS'(1)) begin
			delay_left_m = delay_left_m - DELAY_BITS'(1);
			return;
		end
		run_done = (dir_m == DIR_ACW) ? (step_m == STEP_LAST) : (step_m == STEP_FIRST);
		if (run_done) begin
			seq_left_m = seq_left_m - SEQ_BITS'(1);
			if (seq_left_m == '0) begin
				delay_left_m = '0;
				finish_move();
				return;
			end
		end
		step_m = (dir_m == DIR_ACW) ? step_m + STEP_BITS'(1) : step_m - STEP_BITS'(1);
		delay_left_m = hold_ticks();
		drive_coils();
	endfunction

	// Advance the predictor by one request and return the drive result it should give
	function automatic result_t predict_drive(input logic k, input logic [SAMPLE_BITS-1:0] r_s,
			input logic [SAMPLE_BITS-1:0] f_s, input logic [SAMPLE_BITS-1:0] s_s);
		result_t res;
		logic m1, m2, d1, d2;
		res.taken = 1'b0;
		if (k == KIND_TICK) begin
			count_tick();
		end else if (phase_m == AXIS_IDLE) begin
			m1 = needs_move(r_s, f_s, d1);
			m2 = needs_move(r_s, s_s, d2);
			res.taken = 1'b1;
			second_pend_m = 1'b0;
			if (m1 && begin_move(AXIS_FIRST, d1)) begin
				second_pend_m = m2;
				second_dir_m = d2;
			end else if (m2) begin
				void'(begin_move(AXIS_SECOND, d2));
			end
		end else begin
			samples_dropped++;
		end
		res.coil_first  = first_coils_m;
		res.coil_second = second_coils_m;
		res.busy        = (phase_m != AXIS_IDLE);
		return res;
	endfunction

	// Partner sample: random, equal, or right around the threshold gap
	function automatic logic [SAMPLE_BITS-1:0] partner_of(input logic [SAMPLE_BITS-1:0] base);
		int off;
		int v;
		case ($urandom_range(0, 4))
			0: return SAMPLE_BITS'($urandom);
			1: return base;
			default: begin
				off = int'(cfg_model.light_threshold) + int'($urandom_range(0, 2)) - 1;
				v = ($urandom_range(0, 1) == 1) ? int'(base) + off : int'(base) - off;
				if (v < 0)
					v = 0;
				if (v > SAMPLE_MAX)
					v = SAMPLE_MAX;
				return SAMPLE_BITS'(v);
			end
		endcase
	endfunction

	function automatic void pick_samples(output logic [SAMPLE_BITS-1:0] r_s,
			output logic [SAMPLE_BITS-1:0] f_s, output logic [SAMPLE_BITS-1:0] s_s);
		r_s = SAMPLE_BITS'($urandom);
		f_s = partner_of(r_s);
		s_s = partner_of(r_s);
	endfunction

	// Offer one request; returns at the edge that accepted it with valid still high
	task automatic send_req(input logic k, input logic [SAMPLE_BITS-1:0] r_s,
			input logic [SAMPLE_BITS-1:0] f_s, input logic [SAMPLE_BITS-1:0] s_s);
		int gap;
		gap = 0;
		if (!steady_send) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		light_ref    <= r_s;
		light_first  <= f_s;
		light_second <= s_s;
		do @(posedge clk); while (!in_ready);
		drive_expect_q.push_back(predict_drive(k, r_s, f_s, s_s));
		reqs_sent++;
	endtask

	task automatic send_ticks(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_req(KIND_TICK, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
				SAMPLE_BITS'($urandom));
	endtask

	// Drop valid and let every result come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all registers, plus the unused index which must be ignored
	task automatic set_config(input logic [THRESH_BITS-1:0] thr,
			input logic [DELAY_BITS-1:0] dly, input logic [SEQ_BITS-1:0] seqs);
		wait_drain();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_data  <= CFG_DATA_BITS'(thr);
		@(posedge clk);
		cfg_model.light_threshold = thr;
		cfg_index <= CFG_STEP_DELAY;
		cfg_data  <= CFG_DATA_BITS'(dly);
		@(posedge clk);
		cfg_model.step_delay = dly;
		cfg_index <= CFG_SEQUENCES;
		cfg_data  <= CFG_DATA_BITS'(seqs);
		@(posedge clk);
		cfg_model.sequences_per_move = seqs;
		cfg_index <= CFG_SPARE;
		cfg_data  <= CFG_DATA_BITS'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Idle tick, equal samples, gap exactly at the threshold and one above it
	task automatic test_idle_and_threshold();
		set_config(12'd100, 16'd1, 8'd1);
		send_ticks(1);
		send_req(KIND_SAMPLES, 12'd2048, 12'd2048, 12'd2048);
		send_req(KIND_SAMPLES, 12'd2148, 12'd2048, 12'd2249);
		send_ticks(4);
	endtask

	// Both motors clockwise, second waits for the first; samples while busy are dropped
	task automatic test_both_axes_cw();
		send_req(KIND_SAMPLES, 12'hFFF, 12'h000, 12'h000);
		send_ticks(3);
		send_req(KIND_SAMPLES, 12'h000, 12'hFFF, 12'hFFF);
		send_ticks(5);
	endtask

	// Zero sequences gives an empty move; zero delay holds one tick
	task automatic test_zero_settings();
		set_config(12'd0, 16'd0, 8'd0);
		send_req(KIND_SAMPLES, 12'd1, 12'd0, 12'd2);
		set_config(12'd0, 16'd0, 8'd1);
		send_req(KIND_SAMPLES, 12'h000, 12'hFFF, 12'hFFF);
		send_ticks(8);
	endtask

	// Many runs in one move, first motor only, run to the end
	task automatic test_long_move();
		set_config(12'd0, 16'd1, 8'd40);
		send_req(KIND_SAMPLES, 12'h000, 12'hFFF, 12'h000);
		send_ticks(162);
	endtask

	// Receiver holds off while requests keep coming, so the input side stalls
	task automatic test_backpressure();
		int n;
		logic [SAMPLE_BITS-1:0] r_s, f_s, s_s;
		set_config(12'd50, 16'd2, 8'd1);
		hold_off_req = 1'b1;
		steady_send = 1'b1;
		for (n = 0; n < 48; n++) begin
			pick_samples(r_s, f_s, s_s);
			send_req((n % 12 == 0) ? KIND_SAMPLES : KIND_TICK, r_s, f_s, s_s);
		end
		steady_send = 1'b0;
	endtask

	// Mostly sample sets followed by the ticks that carry the move, with dropped sets mixed in
	task automatic test_random_traffic();
		int phase_n;
		int counted;
		logic [THRESH_BITS-1:0] thr;
		logic [SAMPLE_BITS-1:0] r_s, f_s, s_s;
		for (phase_n = 0; phase_n < RANDOM_PHASES; phase_n++) begin
			case ($urandom_range(0, 2))
				0: thr = '0;
				1: thr = THRESH_BITS'($urandom);
				default: thr = THRESH_BITS'($urandom_range(0, 300));
			endcase
			// nothing can clear the top threshold
			if (phase_n == RANDOM_PHASES - 1)
				thr = '1;
			set_config(thr, DELAY_BITS'($urandom_range(0, 3)), SEQ_BITS'($urandom_range(0, 3)));
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				pick_samples(r_s, f_s, s_s);
				if (phase_m == AXIS_IDLE) begin
					if ($urandom_range(0, 3) != 0) begin
						send_req(KIND_SAMPLES, r_s, f_s, s_s);
						counted++;
					end else begin
						send_req(KIND_TICK, r_s, f_s, s_s);
					end
				end else if ($urandom_range(0, 11) == 0) begin
					send_req(KIND_SAMPLES, r_s, f_s, s_s);
				end else begin
					send_req(KIND_TICK, r_s, f_s, s_s);
					counted++;
				end
			end
		end
	endtask

	// Longest hold per pattern; the move is still running when the run ends
	task automatic test_max_hold();
		set_config(12'd4094, 16'hFFFF, 8'd255);
		send_req(KIND_SAMPLES, 12'hFFF, 12'h000, 12'h000);
		send_ticks(40);
	endtask

	// Receiver stall pattern, with a long hold-off on request
	initial begin : rx_stall_pattern
		rx_mode_e rx_mode;
		int mode_left;
		int held;
		int beat;
		rx_mode = RX_OPEN;
		mode_left = 0;
		beat = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(posedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_e'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				beat++;
				case (rx_mode)
					RX_OPEN: out_ready <= 1'b1;
					RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= (beat % 3 != 0);
				endcase
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_res.coil_first  = coil_first;
			got_res.coil_second = coil_second;
			got_res.busy        = busy_res;
			got_res.taken       = sample_taken;
			results_checked++;
			if (drive_expect_q.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("ERROR: unexpected result coils %h/%h busy %b taken %b",
						got_res.coil_first, got_res.coil_second, got_res.busy, got_res.taken);
			end else begin
				want_res = drive_expect_q.pop_front();
				if (got_res.coil_first !== want_res.coil_first
						|| got_res.coil_second !== want_res.coil_second
						|| got_res.busy !== want_res.busy
						|| got_res.taken !== want_res.taken) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("ERROR: result %0d expected coils %h/%h busy %b taken %b,",
							results_checked, want_res.coil_first, want_res.coil_second,
							want_res.busy, want_res.taken,
							" got coils %h/%h busy %b taken %b", got_res.coil_first,
							got_res.coil_second, got_res.busy, got_res.taken);
				end
			end
		end
	end

	// Run-length guard
	always @(posedge clk)
		cycle_count++;

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
			drive_expect_q.size());
		$display("Regression FAIL");
		$finish;
	end

	// Test sequence
	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_idle_and_threshold();
		test_both_axes_cw();
		test_zero_settings();
		test_long_move();
		test_backpressure();
		test_random_traffic();
		test_max_hold();
		wait_drain();
		$display("Sent %0d requests and checked %0d results: %0d moves,",
			reqs_sent, results_checked, moves_started,
			" %0d sample sets dropped while busy", samples_dropped);
		$display("Thresholds 0..4095, hold 0..65535 ticks, 0..255 runs per move; %0d mismatches",
			err_count);
		if (err_count == 0 && drive_expect_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
